### rtl/bdle_pkg.sv
`timescale 1ns / 1ps

package bdle_pkg;

  localparam int TIME_BITS   = 32;
  localparam int SAMPLE_BITS = 10;
  localparam int DIFF_BITS   = SAMPLE_BITS + 2;

  localparam int LONG_BITS   = 16;
  localparam int DEB_BITS    = 8;
  localparam int TGT_BITS    = 10;
  localparam int ID_BITS     = 8;
  localparam int CODE_BITS   = 3;
  localparam int IDX_BITS    = 3;
  localparam int CFG_BITS    = 16;

  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_BITS  = $clog2(Q_DEPTH);
  localparam int Q_CNT_BITS  = $clog2(Q_DEPTH + 1);

  localparam logic [LONG_BITS-1:0] LONGPRESS_RESET = LONG_BITS'(1000);
  localparam logic [DEB_BITS-1:0]  DEBOUNCE_RESET  = DEB_BITS'(50);

  // register indexes
  localparam logic [IDX_BITS-1:0] REG_LONGPRESS = 3'd0;
  localparam logic [IDX_BITS-1:0] REG_DEBOUNCE  = 3'd1;
  localparam logic [IDX_BITS-1:0] REG_MODE      = 3'd2;
  localparam logic [IDX_BITS-1:0] REG_TARGET    = 3'd3;
  localparam logic [IDX_BITS-1:0] REG_DELTA     = 3'd4;
  localparam logic [IDX_BITS-1:0] REG_BUTTON    = 3'd5;

  // event codes
  localparam logic [CODE_BITS-1:0] EV_DOWN        = 3'd0;
  localparam logic [CODE_BITS-1:0] EV_UP          = 3'd1;
  localparam logic [CODE_BITS-1:0] EV_CLICK       = 3'd2;
  localparam logic [CODE_BITS-1:0] EV_LONGPRESS   = 3'd3;
  localparam logic [CODE_BITS-1:0] EV_HOLD        = 3'd4;
  localparam logic [CODE_BITS-1:0] EV_UNLONGPRESS = 3'd5;

  // events raised by one scan: one or two codes
  typedef struct packed {
    logic [ID_BITS-1:0]   id;
    logic                 two;
    logic [CODE_BITS-1:0] code0;
    logic [CODE_BITS-1:0] code1;
  } ev_entry_t;

endpackage

### rtl/bdle_front.sv
`timescale 1ns / 1ps

module bdle_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  take,
  input  logic                                  level,
  input  logic [bdle_pkg::SAMPLE_BITS-1:0]      analog_sample,
  input  logic [bdle_pkg::TIME_BITS-1:0]        now_ms,
  input  logic                                  cfg_we,
  input  logic [bdle_pkg::IDX_BITS-1:0]         cfg_index,
  input  logic [bdle_pkg::CFG_BITS-1:0]         cfg_data,
  output logic                                  q_push,
  output bdle_pkg::ev_entry_t                   q_entry
);

  logic [bdle_pkg::LONG_BITS-1:0]   longpress_ms;
  logic [bdle_pkg::DEB_BITS-1:0]    settle_ms;
  logic                             analog_mode;
  logic [bdle_pkg::SAMPLE_BITS-1:0] analog_target;
  logic [bdle_pkg::SAMPLE_BITS-1:0] analog_delta;
  logic [bdle_pkg::ID_BITS-1:0]     button_number;

  logic                             previous_level;
  logic [bdle_pkg::TIME_BITS-1:0]   debounce_stamp;
  logic [bdle_pkg::TIME_BITS-1:0]   press_stamp;
  logic                             press_active;
  logic                             long_pressed;

  logic                             previous_level_next;
  logic [bdle_pkg::TIME_BITS-1:0]   debounce_stamp_next;
  logic [bdle_pkg::TIME_BITS-1:0]   press_stamp_next;
  logic                             press_active_next;
  logic                             long_pressed_next;

  logic signed [bdle_pkg::DIFF_BITS-1:0] diff;
  logic signed [bdle_pkg::DIFF_BITS-1:0] dlt;
  logic                             pressed;
  logic                             changed;
  logic [bdle_pkg::TIME_BITS-1:0]   stable_for;
  logic [bdle_pkg::TIME_BITS-1:0]   held_for;
  logic                             settled;

  always_ff @(posedge clk) begin
    if (rst) begin
      longpress_ms  <= bdle_pkg::LONGPRESS_RESET;
      settle_ms     <= bdle_pkg::DEBOUNCE_RESET;
      analog_mode   <= 1'b0;
      analog_target <= '0;
      analog_delta  <= '0;
      button_number <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bdle_pkg::REG_LONGPRESS: longpress_ms  <= cfg_data[bdle_pkg::LONG_BITS-1:0];
        bdle_pkg::REG_DEBOUNCE:  settle_ms     <= cfg_data[bdle_pkg::DEB_BITS-1:0];
        bdle_pkg::REG_MODE:      analog_mode   <= cfg_data[0];
        bdle_pkg::REG_TARGET:    analog_target <= cfg_data[bdle_pkg::SAMPLE_BITS-1:0];
        bdle_pkg::REG_DELTA:     analog_delta  <= cfg_data[bdle_pkg::SAMPLE_BITS-1:0];
        bdle_pkg::REG_BUTTON:    button_number <= cfg_data[bdle_pkg::ID_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    diff    = $signed({2'b00, analog_sample}) - $signed({2'b00, analog_target});
    dlt     = $signed({2'b00, analog_delta});
    pressed = analog_mode ? ((diff < dlt) && (diff > -dlt)) : level;
    changed = (pressed != previous_level);
    // a fresh change restarts the window, so nothing elapsed yet
    stable_for = changed ? '0 : (now_ms - debounce_stamp);
    held_for   = now_ms - press_stamp;
    settled    = (stable_for > bdle_pkg::TIME_BITS'(settle_ms));

    previous_level_next = pressed;
    debounce_stamp_next = changed ? now_ms : debounce_stamp;
    press_stamp_next    = press_stamp;
    press_active_next   = press_active;
    long_pressed_next   = long_pressed;

    q_push        = 1'b0;
    q_entry.id    = button_number;
    q_entry.two   = 1'b0;
    q_entry.code0 = bdle_pkg::EV_DOWN;
    q_entry.code1 = bdle_pkg::EV_HOLD;

    if (settled) begin
      if (pressed) begin
        if (press_active) begin
          if (!long_pressed && (held_for >= bdle_pkg::TIME_BITS'(longpress_ms))) begin
            long_pressed_next = 1'b1;
            q_push            = 1'b1;
            q_entry.two       = 1'b1;
            q_entry.code0     = bdle_pkg::EV_LONGPRESS;
            q_entry.code1     = bdle_pkg::EV_HOLD;
          end else if (long_pressed) begin
            q_push        = 1'b1;
            q_entry.code0 = bdle_pkg::EV_HOLD;
          end
        end else begin
          q_push            = 1'b1;
          q_entry.code0     = bdle_pkg::EV_DOWN;
          press_stamp_next  = now_ms;
          press_active_next = 1'b1;
        end
      end else if (press_active) begin
        q_push = 1'b1;
        if (!long_pressed) begin
          q_entry.two   = 1'b1;
          q_entry.code0 = bdle_pkg::EV_UP;
          q_entry.code1 = bdle_pkg::EV_CLICK;
        end else begin
          q_entry.code0     = bdle_pkg::EV_UNLONGPRESS;
          long_pressed_next = 1'b0;
        end
        press_active_next = 1'b0;
      end
    end
    q_push = q_push & take;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_level <= 1'b0;
      debounce_stamp <= '0;
      press_stamp    <= '0;
      press_active   <= 1'b0;
      long_pressed   <= 1'b0;
    end else if (take) begin
      previous_level <= previous_level_next;
      debounce_stamp <= debounce_stamp_next;
      press_stamp    <= press_stamp_next;
      press_active   <= press_active_next;
      long_pressed   <= long_pressed_next;
    end
  end

  // a long press is only ever tracked inside an active press
  a_long_needs_press: assert property (@(posedge clk) disable iff (rst)
    long_pressed |-> press_active) else $error("long press without active press");

  a_two_codes: assert property (@(posedge clk) disable iff (rst)
    (q_push && q_entry.two) |->
      (q_entry.code1 == bdle_pkg::EV_CLICK || q_entry.code1 == bdle_pkg::EV_HOLD))
    else $error("bad second event");

endmodule

### rtl/bdle_queue.sv
`timescale 1ns / 1ps

module bdle_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr,
  input  bdle_pkg::ev_entry_t wr_entry,
  input  logic                rd,
  output bdle_pkg::ev_entry_t rd_entry,
  output logic                full,
  output logic                avail
);

  bdle_pkg::ev_entry_t               mem [bdle_pkg::Q_DEPTH];
  logic [bdle_pkg::Q_PTR_BITS-1:0]   wptr;
  logic [bdle_pkg::Q_PTR_BITS-1:0]   rptr;
  logic [bdle_pkg::Q_CNT_BITS-1:0]   count;
  logic                              do_rd;

  function automatic logic [bdle_pkg::Q_CNT_BITS-1:0] Q_CNT(input logic b);
    Q_CNT = {{(bdle_pkg::Q_CNT_BITS-1){1'b0}}, b};
  endfunction

  assign full     = (count == bdle_pkg::Q_CNT_BITS'(bdle_pkg::Q_DEPTH));
  assign avail    = (count != '0);
  assign do_rd    = rd && avail;
  assign rd_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + Q_CNT(wr) - Q_CNT(do_rd);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= bdle_pkg::Q_CNT_BITS'(bdle_pkg::Q_DEPTH)) else $error("queue overflow");

endmodule

### rtl/bdle_back.sv
`timescale 1ns / 1ps

module bdle_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_avail,
  input  bdle_pkg::ev_entry_t           q_entry,
  output logic                          q_pop,
  input  logic                          pop,
  output logic                          empty,
  output logic [bdle_pkg::ID_BITS-1:0]  button_id,
  output logic [bdle_pkg::CODE_BITS-1:0] event_code,
  output logic                          last
);

  bdle_pkg::ev_entry_t cur;
  logic                cur_valid;
  logic                sel;
  logic                taken;
  logic                done;

  assign empty      = !cur_valid;
  assign button_id  = cur.id;
  assign event_code = sel ? cur.code1 : cur.code0;
  assign last       = !cur.two || sel;
  assign taken      = pop && cur_valid;
  assign done       = taken && last;
  // refill the output register when it is free or its last event leaves
  assign q_pop      = (!cur_valid || done) && q_avail;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      sel       <= 1'b0;
    end else begin
      if (!cur_valid || done) begin
        cur_valid <= q_avail;
        sel       <= 1'b0;
      end else if (taken) begin
        sel <= 1'b1;
      end
    end
  end

  a_sel_needs_two: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && sel) |-> cur.two) else $error("second event of single entry");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (taken && cur.two && !sel) |=> (!empty && sel)) else $error("second event lost");

endmodule

### rtl/button_debounce_longpress_events_top.sv
`timescale 1ns / 1ps
// Channel  | Direction | Handshake         | Payload
// scan     | in        | push / full       | level, analog_sample, now_ms
// event    | out       | empty / pop       | button_id, event_code, last
// config   | in        | cfg_valid / ready | cfg_index, cfg_data
//
// One scan is taken every cycle while the event queue has room; a scan's
// events pass through the queue and then the output register to the result ports.
// Events leave one per cycle while pop is held; a two-event scan occupies
// the output for two pops; a four-entry queue absorbs bursts between sides.
// Reset is synchronous and restores state and registers; no clearing pass.
// full rises only when all four queue entries are occupied, even with pop held.

module button_debounce_longpress_events_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  level,
  input  logic [bdle_pkg::SAMPLE_BITS-1:0]      analog_sample,
  input  logic [bdle_pkg::TIME_BITS-1:0]        now_ms,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [bdle_pkg::ID_BITS-1:0]          button_id,
  output logic [bdle_pkg::CODE_BITS-1:0]        event_code,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [bdle_pkg::IDX_BITS-1:0]         cfg_index,
  input  logic [bdle_pkg::CFG_BITS-1:0]         cfg_data
);

  logic                take;
  logic                f_push;
  bdle_pkg::ev_entry_t f_entry;
  logic                q_pop;
  bdle_pkg::ev_entry_t q_entry;
  logic                q_avail;

  assign cfg_ready = 1'b1;
  assign take      = push && !full;

  bdle_front u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .level         (level),
    .analog_sample (analog_sample),
    .now_ms        (now_ms),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .q_push        (f_push),
    .q_entry       (f_entry)
  );

  bdle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (f_push),
    .wr_entry (f_entry),
    .rd       (q_pop),
    .rd_entry (q_entry),
    .full     (full),
    .avail    (q_avail)
  );

  bdle_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_avail    (q_avail),
    .q_entry    (q_entry),
    .q_pop      (q_pop),
    .pop        (pop),
    .empty      (empty),
    .button_id  (button_id),
    .event_code (event_code),
    .last       (last)
  );

endmodule
